// ===== rtl/qpts_pkg.sv =====
// ----------------------------------------------------------------------------
// qpts_pkg: shared types and constants for the projective quad weight setup
// Field widths, divider staging and status codes used across the block.
// ----------------------------------------------------------------------------
package qpts_pkg;

	localparam int COORD_BITS  = 16;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int PROD_BITS   = 2 * DIFF_BITS;
	localparam int CROSS_BITS  = PROD_BITS + 1;
	localparam int WEIGHT_BITS = 24;
	localparam int WEIGHT_FRAC = WEIGHT_BITS - 8;
	localparam int LANES       = 4;
	localparam int DIV_STEP    = 4;
	localparam int DIV_STAGES  = WEIGHT_BITS / DIV_STEP;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_PARALLEL = 2'd1,
		STATUS_S_RANGE  = 2'd2,
		STATUS_T_RANGE  = 2'd3
	} status_t;

	// Running state of one restoring division lane
	typedef struct packed {
		logic [CROSS_BITS-1:0]  rem;
		logic [WEIGHT_BITS-1:0] quo;
		logic [CROSS_BITS-1:0]  den;
	} div_t;

endpackage

// ===== rtl/qpts_div_stage.sv =====
// ----------------------------------------------------------------------------
// qpts_div_stage: one registered stage of a restoring divider lane
// Retires DIV_STEP quotient bits per stage; the numerator bits shift out of
// the top of the quotient field as the result bits shift in at the bottom.
// ----------------------------------------------------------------------------
module qpts_div_stage (
	input  logic          clk,
	input  logic          en,
	input  qpts_pkg::div_t d_in,
	output qpts_pkg::div_t d_out
);

	qpts_pkg::div_t nxt;

	// Compare and subtract once per quotient bit
	always_comb begin
		logic [qpts_pkg::CROSS_BITS-1:0] r;
		logic [qpts_pkg::WEIGHT_BITS-1:0] q;
		r = d_in.rem;
		q = d_in.quo;
		for (int i = 0; i < qpts_pkg::DIV_STEP; i++) begin
			r = {r[qpts_pkg::CROSS_BITS-2:0], q[qpts_pkg::WEIGHT_BITS-1]};
			q = {q[qpts_pkg::WEIGHT_BITS-2:0], 1'b0};
			if (r >= d_in.den) begin
				r = r - d_in.den;
				q[0] = 1'b1;
			end
		end
		nxt.rem = r;
		nxt.quo = q;
		nxt.den = d_in.den;
	end

	// Hold while en is low: this stage is full and the stage downstream is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

// ===== rtl/quad_projective_texcoord_setup_core.sv =====
// ----------------------------------------------------------------------------
// quad_projective_texcoord_setup_core: projective weights for a screen quad
// Intersects the quad diagonals and returns q0..q3 in unsigned Q8.16.
// Throughput: one quad per cycle while no result stall holds the pipeline; four
// divider lanes of six stages, four quotient bits per stage, set the depth.
// Each stage stalls only when it is full and the next cannot take, so bubbles
// close up. Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module quad_projective_texcoord_setup_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [qpts_pkg::COORD_BITS-1:0] corner0_x,
	input  logic signed [qpts_pkg::COORD_BITS-1:0] corner0_y,
	input  logic signed [qpts_pkg::COORD_BITS-1:0] corner1_x,
	input  logic signed [qpts_pkg::COORD_BITS-1:0] corner1_y,
	input  logic signed [qpts_pkg::COORD_BITS-1:0] corner2_x,
	input  logic signed [qpts_pkg::COORD_BITS-1:0] corner2_y,
	input  logic signed [qpts_pkg::COORD_BITS-1:0] corner3_x,
	input  logic signed [qpts_pkg::COORD_BITS-1:0] corner3_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic [qpts_pkg::WEIGHT_BITS-1:0]    weight0,
	output logic [qpts_pkg::WEIGHT_BITS-1:0]    weight1,
	output logic [qpts_pkg::WEIGHT_BITS-1:0]    weight2,
	output logic [qpts_pkg::WEIGHT_BITS-1:0]    weight3
);

	localparam int CB = qpts_pkg::CROSS_BITS;
	localparam int WB = qpts_pkg::WEIGHT_BITS;
	localparam int NL = qpts_pkg::LANES;
	localparam int ND = qpts_pkg::DIV_STAGES;

	// Stage registers
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [qpts_pkg::DIFF_BITS-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [qpts_pkg::PROD_BITS-1:0] axby_s2, aybx_s2, axcy_s2, aycx_s2;
	logic signed [qpts_pkg::PROD_BITS-1:0] bxcy_s2, bycx_s2;
	logic signed [CB-1:0] cross_s3, ns_s3, nt_s3;
	qpts_pkg::status_t status_s4, status_s5;
	logic [CB-1:0] cross_s4;
	logic [CB-1:0] den_s4 [NL];
	logic [NL-1:0] sat_s5;
	qpts_pkg::div_t seed_s5 [NL];

	// Divider pipeline: index 0 is the stage 5 register
	qpts_pkg::div_t div_s [ND+1][NL];
	logic               dvalid_s  [ND+1];
	qpts_pkg::status_t  dstatus_s [ND+1];
	logic [NL-1:0]      dsat_s    [ND+1];
	logic               en_d      [ND+1];

	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		en_d[ND] = !dvalid_s[ND] || !out_stall;
		for (int j = ND - 1; j >= 1; j--) begin
			en_d[j] = !dvalid_s[j] || en_d[j+1];
		end
		en_d[0] = 1'b0;
	end
	assign en_s5 = !valid_s5 || en_d[1];
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: diagonal and edge vectors
	always_ff @(posedge clk) begin
		if (en_s1) begin
			ax_s1 <= qpts_pkg::DIFF_BITS'(corner2_x) - qpts_pkg::DIFF_BITS'(corner0_x);
			ay_s1 <= qpts_pkg::DIFF_BITS'(corner2_y) - qpts_pkg::DIFF_BITS'(corner0_y);
			bx_s1 <= qpts_pkg::DIFF_BITS'(corner3_x) - qpts_pkg::DIFF_BITS'(corner1_x);
			by_s1 <= qpts_pkg::DIFF_BITS'(corner3_y) - qpts_pkg::DIFF_BITS'(corner1_y);
			cx_s1 <= qpts_pkg::DIFF_BITS'(corner0_x) - qpts_pkg::DIFF_BITS'(corner1_x);
			cy_s1 <= qpts_pkg::DIFF_BITS'(corner0_y) - qpts_pkg::DIFF_BITS'(corner1_y);
		end
	end

	// Stage 2: cross-product terms
	always_ff @(posedge clk) begin
		if (en_s2) begin
			axby_s2 <= ax_s1 * by_s1;
			aybx_s2 <= ay_s1 * bx_s1;
			axcy_s2 <= ax_s1 * cy_s1;
			aycx_s2 <= ay_s1 * cx_s1;
			bxcy_s2 <= bx_s1 * cy_s1;
			bycx_s2 <= by_s1 * cx_s1;
		end
	end

	// Stage 3: cross and the two numerators
	always_ff @(posedge clk) begin
		if (en_s3) begin
			cross_s3 <= CB'(axby_s2) - CB'(aybx_s2);
			ns_s3    <= CB'(axcy_s2) - CB'(aycx_s2);
			nt_s3    <= CB'(bxcy_s2) - CB'(bycx_s2);
		end
	end

	// Stage 4: fold the sign, classify and form denominators
	logic signed [CB-1:0] cp, sp, tp;
	qpts_pkg::status_t st4;
	always_comb begin
		cp = cross_s3[CB-1] ? -cross_s3 : cross_s3;
		sp = cross_s3[CB-1] ? -ns_s3 : ns_s3;
		tp = cross_s3[CB-1] ? -nt_s3 : nt_s3;
		if (cross_s3 == '0) begin
			st4 = qpts_pkg::STATUS_PARALLEL;
		end else if (sp[CB-1] || sp == '0 || sp >= cp) begin
			st4 = qpts_pkg::STATUS_S_RANGE;
		end else if (tp[CB-1] || tp == '0 || tp >= cp) begin
			st4 = qpts_pkg::STATUS_T_RANGE;
		end else begin
			st4 = qpts_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			status_s4 <= st4;
			cross_s4  <= cp;
			den_s4[0] <= cp - tp;
			den_s4[1] <= cp - sp;
			den_s4[2] <= tp;
			den_s4[3] <= sp;
		end
	end

	// Stage 5: saturation test and divider seed
	always_ff @(posedge clk) begin
		if (en_s5) begin
			status_s5 <= status_s4;
			for (int k = 0; k < NL; k++) begin
				sat_s5[k] <= {8'b0, cross_s4} >= {den_s4[k], 8'b0};
				seed_s5[k].rem <= {8'b0, cross_s4[CB-1:8]};
				seed_s5[k].quo <= {cross_s4[7:0], qpts_pkg::WEIGHT_FRAC'(0)};
				seed_s5[k].den <= den_s4[k];
			end
		end
	end

	for (genvar k = 0; k < NL; k++) begin : g_seed
		assign div_s[0][k] = seed_s5[k];
	end

	assign dvalid_s[0]  = valid_s5;
	assign dstatus_s[0] = status_s5;
	assign dsat_s[0]    = sat_s5;

	// Divider stages, four lanes
	for (genvar j = 1; j <= ND; j++) begin : g_div
		for (genvar k = 0; k < NL; k++) begin : g_lane
			qpts_div_stage u_stage (
				.clk   (clk),
				.en    (en_d[j]),
				.d_in  (div_s[j-1][k]),
				.d_out (div_s[j][k])
			);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvalid_s[j] <= 1'b0;
			end else if (en_d[j]) begin
				dvalid_s[j] <= dvalid_s[j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en_d[j]) begin
				dstatus_s[j] <= dstatus_s[j-1];
				dsat_s[j]    <= dsat_s[j-1];
			end
		end
	end

	// Drive result: saturate, and clear weights on a bad quad
	logic [WB-1:0] w [NL];
	always_comb begin
		for (int k = 0; k < NL; k++) begin
			if (dstatus_s[ND] != qpts_pkg::STATUS_OK) begin
				w[k] = '0;
			end else if (dsat_s[ND][k]) begin
				w[k] = '1;
			end else begin
				w[k] = div_s[ND][k].quo;
			end
		end
	end

	assign out_valid = dvalid_s[ND];
	assign status    = dstatus_s[ND];
	assign weight0   = w[0];
	assign weight1   = w[1];
	assign weight2   = w[2];
	assign weight3   = w[3];

endmodule

// ===== rtl/qpts_checker.sv =====
// ----------------------------------------------------------------------------
// qpts_checker: port-level checks for the projective quad weight setup
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module qpts_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [1:0]                       status,
	input logic [qpts_pkg::WEIGHT_BITS-1:0] weight0,
	input logic [qpts_pkg::WEIGHT_BITS-1:0] weight1,
	input logic [qpts_pkg::WEIGHT_BITS-1:0] weight2,
	input logic [qpts_pkg::WEIGHT_BITS-1:0] weight3
);

	// Hold a stalled result: it stays valid with status and weight0 stable
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(weight0))
		else $error("stalled result changed");

	// Back-pressure at the input comes only from a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// Clear all weights on a rejected quad
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != qpts_pkg::STATUS_OK |->
		weight0 == '0 && weight1 == '0 && weight2 == '0 && weight3 == '0)
		else $error("weights not cleared on bad status");

	// Every weight of an accepted quad is at least one
	a_ok_above_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == qpts_pkg::STATUS_OK |->
		weight0[qpts_pkg::WEIGHT_BITS-1:qpts_pkg::WEIGHT_FRAC] != '0 &&
		weight1[qpts_pkg::WEIGHT_BITS-1:qpts_pkg::WEIGHT_FRAC] != '0 &&
		weight2[qpts_pkg::WEIGHT_BITS-1:qpts_pkg::WEIGHT_FRAC] != '0 &&
		weight3[qpts_pkg::WEIGHT_BITS-1:qpts_pkg::WEIGHT_FRAC] != '0)
		else $error("weight below one on valid quad");

endmodule

bind quad_projective_texcoord_setup_core qpts_checker u_qpts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.weight0   (weight0),
	.weight1   (weight1),
	.weight2   (weight2),
	.weight3   (weight3)
);

// ===== bench/quad_projective_texcoord_setup_core_tb.sv =====
// ----------------------------------------------------------------------------
// quad_projective_texcoord_setup_core_tb: self-checking bench for quad weights
// Drives screen quads through the valid/stall input channel, predicts status
// and q0..q3 for each transfer, and checks every result transfer in order
// against the oldest prediction, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quad_projective_texcoord_setup_core_tb;

	localparam int  WATCHDOG_LIMIT = 4000;
	localparam int  DRAIN_CYCLES   = 24;
	localparam int  RANDOM_QUADS   = 680;
	localparam longint WMAX        = (longint'(1) << qpts_pkg::WEIGHT_BITS) - 1;

	typedef logic signed [qpts_pkg::COORD_BITS-1:0] corner_set_t [8];

	typedef struct {
		qpts_pkg::status_t                st;
		logic [qpts_pkg::WEIGHT_BITS-1:0] q [4];
	} quad_weights_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [qpts_pkg::COORD_BITS-1:0] corner0_x, corner0_y, corner1_x, corner1_y;
	logic signed [qpts_pkg::COORD_BITS-1:0] corner2_x, corner2_y, corner3_x, corner3_y;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic [qpts_pkg::WEIGHT_BITS-1:0] weight0, weight1, weight2, weight3;

	quad_weights_t pending_weights [$];
	int mismatches;
	int idle_cycles;
	int stall_left;
	bit no_idle;

	quad_projective_texcoord_setup_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.corner0_x(corner0_x), .corner0_y(corner0_y),
		.corner1_x(corner1_x), .corner1_y(corner1_y),
		.corner2_x(corner2_x), .corner2_y(corner2_y),
		.corner3_x(corner3_x), .corner3_y(corner3_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status),
		.weight0(weight0), .weight1(weight1), .weight2(weight2), .weight3(weight3)
	);

	// Clock: 20 ns period
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// floor(num * 2^frac / den), saturating at the top of the weight range
	function automatic logic [qpts_pkg::WEIGHT_BITS-1:0] scaled_ratio(input longint num,
		input longint den);
		logic [63:0] quo;
		begin
			quo = (64'(num) << qpts_pkg::WEIGHT_FRAC) / 64'(den);
			if (quo > 64'(WMAX))
				quo = 64'(WMAX);
			return quo[qpts_pkg::WEIGHT_BITS-1:0];
		end
	endfunction

	// Intersect the diagonals and form the projective weights
	function automatic quad_weights_t predict_weights(input corner_set_t c);
		longint ax, ay, bx, by, cx, cy, crs, ns, nt;
		quad_weights_t r;
		begin
			ax = longint'(c[4]) - longint'(c[0]);
			ay = longint'(c[5]) - longint'(c[1]);
			bx = longint'(c[6]) - longint'(c[2]);
			by = longint'(c[7]) - longint'(c[3]);
			cx = longint'(c[0]) - longint'(c[2]);
			cy = longint'(c[1]) - longint'(c[3]);
			crs = ax * by - ay * bx;
			ns  = ax * cy - ay * cx;
			nt  = bx * cy - by * cx;
			for (int k = 0; k < 4; k++)
				r.q[k] = '0;
			if (crs == 0) begin
				r.st = qpts_pkg::STATUS_PARALLEL;
			end else begin
				if (crs < 0) begin
					crs = -crs;
					ns  = -ns;
					nt  = -nt;
				end
				if (ns <= 0 || ns >= crs) begin
					r.st = qpts_pkg::STATUS_S_RANGE;
				end else if (nt <= 0 || nt >= crs) begin
					r.st = qpts_pkg::STATUS_T_RANGE;
				end else begin
					r.st   = qpts_pkg::STATUS_OK;
					r.q[0] = scaled_ratio(crs, crs - nt);
					r.q[1] = scaled_ratio(crs, crs - ns);
					r.q[2] = scaled_ratio(crs, nt);
					r.q[3] = scaled_ratio(crs, ns);
				end
			end
			return r;
		end
	endfunction

	// Send one quad; the transfer completes at a rising edge without stall
	task automatic send_quad(input corner_set_t c);
		int gap;
		begin
			gap = no_idle ? 0 : $urandom_range(0, 19);
			@(negedge clk);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			{corner0_x, corner0_y, corner1_x, corner1_y} <= {c[0], c[1], c[2], c[3]};
			{corner2_x, corner2_y, corner3_x, corner3_y} <= {c[4], c[5], c[6], c[7]};
			in_valid <= 1'b1;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			pending_weights.push_back(predict_weights(c));
		end
	endtask

	task automatic send_square(input int x, input int y, input int h);
		corner_set_t c;
		begin
			c = '{16'(x - h), 16'(y - h), 16'(x + h), 16'(y - h),
				16'(x + h), 16'(y + h), 16'(x - h), 16'(y + h)};
			send_quad(c);
		end
	endtask

	// Extremes of every coordinate
	task automatic test_extremes;
		corner_set_t c;
		begin
			c = '{default: 16'sh8000};
			send_quad(c);
			c = '{default: 16'sh7fff};
			send_quad(c);
			c = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
				16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff};
			send_quad(c);
			c = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
				16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000};
			send_quad(c);
			c = '{16'sh8000, 16'sh0000, 16'sh0000, 16'sh8000,
				16'sh7fff, 16'sh0000, 16'sh0000, 16'sh7fff};
			send_quad(c);
		end
	endtask

	// Well-formed quads, including the weight saturating near a corner
	task automatic test_convex;
		corner_set_t c;
		begin
			send_square(0, 0, 16384);
			send_square(100, -200, 1);
			c = '{16'sh8000, 16'sh0000, 16'sh0000, 16'sh8000,
				16'sh0001, 16'sh0000, 16'sh0000, 16'sh7fff};
			send_quad(c);
			c = '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh8000,
				16'sh8000, 16'sh0000, 16'sh0000, 16'sh7fff};
			send_quad(c);
			c = '{-16'sd30000, -16'sd1000, 16'sd25000, -16'sd20000,
				16'sd2000, 16'sd3000, -16'sd100, 16'sd31000};
			send_quad(c);
		end
	endtask

	// Parallel diagonals, s outside the span and t outside the span
	task automatic test_degenerate;
		corner_set_t c;
		begin
			c = '{default: 16'sd0};
			send_quad(c);
			c = '{16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd200, 16'sd0, 16'sd300, 16'sd0};
			send_quad(c);
			// corners out of order: bow-tie
			c = '{-16'sd1000, -16'sd1000, 16'sd1000, 16'sd1000,
				16'sd1000, -16'sd1000, -16'sd1000, 16'sd1000};
			send_quad(c);
			// dart: diagonal 1-3 stops short of diagonal 0-2
			c = '{-16'sd1000, 16'sd0, 16'sd0, -16'sd1000,
				16'sd1000, 16'sd0, 16'sd0, -16'sd500};
			send_quad(c);
			// dart: diagonal 0-2 stops short of diagonal 1-3
			c = '{-16'sd1000, 16'sd0, 16'sd0, -16'sd1000,
				-16'sd500, 16'sd0, 16'sd0, 16'sd1000};
			send_quad(c);
			// intersection exactly on a corner
			c = '{-16'sd1000, 16'sd0, 16'sd0, -16'sd1000,
				16'sd1000, 16'sd0, 16'sd0, 16'sd0};
			send_quad(c);
		end
	endtask

	// Mostly convex quads with random size and position, some raw noise
	task automatic test_random;
		corner_set_t c;
		int cx, cy, span;
		begin
			for (int n = 0; n < RANDOM_QUADS; n++) begin
				no_idle = (n / 100) % 3 == 1;
				if ($urandom_range(0, 4) == 0) begin
					for (int k = 0; k < 8; k++)
						c[k] = 16'($urandom);
				end else begin
					case ($urandom_range(0, 2))
						0: span = 4;
						1: span = 300;
						default: span = 16000;
					endcase
					cx = $urandom_range(0, 16000) - 8000;
					cy = $urandom_range(0, 16000) - 8000;
					c[0] = 16'(cx - $urandom_range(1, span));
					c[1] = 16'(cy - $urandom_range(1, span));
					c[2] = 16'(cx + $urandom_range(1, span));
					c[3] = 16'(cy - $urandom_range(1, span));
					c[4] = 16'(cx + $urandom_range(1, span));
					c[5] = 16'(cy + $urandom_range(1, span));
					c[6] = 16'(cx - $urandom_range(1, span));
					c[7] = 16'(cy + $urandom_range(1, span));
				end
				send_quad(c);
			end
			no_idle = 1'b0;
		end
	endtask

	// Result side stall: hold for a drawn number of cycles after each transfer
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check each result transfer against the oldest prediction
	always @(posedge clk) begin
		quad_weights_t exp_w;
		logic [qpts_pkg::WEIGHT_BITS-1:0] got [4];
		bit bad;
		if (arst_n && out_valid && !out_stall) begin
			stall_left = no_idle ? 0 : $urandom_range(0, 19);
			got = '{weight0, weight1, weight2, weight3};
			if (pending_weights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: status %0d", status);
			end else begin
				exp_w = pending_weights.pop_front();
				bad = status !== exp_w.st;
				for (int k = 0; k < 4; k++)
					if (got[k] !== exp_w.q[k])
						bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status %0d/%0d q %h %h %h %h / %h %h %h %h",
							exp_w.st, status, exp_w.q[0], exp_w.q[1], exp_w.q[2],
							exp_w.q[3], got[0], got[1], got[2], got[3]);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		mismatches  = 0;
		idle_cycles = 0;
		stall_left  = 0;
		no_idle     = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		out_stall   = 1'b0;
		{corner0_x, corner0_y, corner1_x, corner1_y} = '0;
		{corner2_x, corner2_y, corner3_x, corner3_y} = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_extremes;
		test_convex;
		test_degenerate;
		test_random;

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_weights.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_weights.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== quad_projective_texcoord_setup_core.f =====
rtl/qpts_pkg.sv
rtl/qpts_div_stage.sv
rtl/quad_projective_texcoord_setup_core.sv
rtl/qpts_checker.sv
bench/quad_projective_texcoord_setup_core_tb.sv
